[design/linear_probing_hash_table_top_assert.svh]
// Assertion macros for the hash table top level.
// Each macro checks on the rising edge of clk and is quiet while arst_n is low.
`ifndef LINEAR_PROBING_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBING_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/lpht_pkg.sv]
`timescale 1ns / 1ps

package lpht_pkg;

	localparam int unsigned DEPTH_DEF    = 1024;
	localparam int unsigned KEY_BITS_DEF = 31;

	// size register, result fields
	localparam int unsigned CFG_W  = 11;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned SLOT_W = 10;

	localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

	// key bits consumed per step of the remainder unit
	localparam int unsigned DIGIT_BITS = 4;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FOUND    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_MISSING  = 2'd3;

	// zero maps to one, anything above the memory depth saturates
	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
			input int unsigned depth);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (32'(v) > depth) begin
			r = CFG_W'(depth);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[design/linear_probing_hash_table_top.sv]
`timescale 1ns / 1ps
// Flow: once start is taken, the key modulo size gives the home slot, then the probe walk
// checks slots from there until done pulses; the key modulo size takes one 4-bit digit per cycle.
// No new item is taken while one is in flight; busy drops the cycle done is up;
// the probe walk reads one slot per cycle through the single read port of the slot memory.
// Results cannot be stalled.
// Reset: size returns to 1024 (clamped to TABLE_DEPTH), then a clearing pass empties every
// slot with busy high; every size write starts the same pass again.
module linear_probing_hash_table_top #(
	parameter int unsigned TABLE_DEPTH = lpht_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS    = lpht_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lpht_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [KEY_BITS-1:0]         key,
	output logic                        done,
	output logic [lpht_pkg::STAT_W-1:0] status,
	output logic [lpht_pkg::SLOT_W-1:0] slot
);
	import lpht_pkg::*;

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = ((IW > CFG_W) ? IW : CFG_W) + 1;
	localparam int unsigned MW = KEY_BITS + 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE
	} state_t;

	state_t              state_q;
	logic [IW-1:0]       clr_q;
	logic [CFG_W-1:0]    size_q;
	logic [KEY_BITS-1:0] key_q;
	logic                act_q;
	logic [IW-1:0]       chk_idx_q;
	logic [CFG_W-1:0]    n_q;
	logic                done_q;
	logic [STAT_W-1:0]   status_q;
	logic [SLOT_W-1:0]   slot_q;

	// slot memory: {valid, key}
	logic [MW-1:0]       slot_mem_q [TABLE_DEPTH];
	logic [MW-1:0]       rd_word_s1;

	logic                accept;
	logic                mod_done;
	logic [CFG_W-1:0]    mod_rem;
	logic [IW-1:0]       home;
	logic [CW-1:0]       idx_inc;
	logic [IW-1:0]       nxt_idx;
	logic                last_probe;
	logic                rd_valid;
	logic                rd_match;
	logic                mem_re;
	logic [IW-1:0]       mem_raddr;
	logic                mem_we;
	logic [IW-1:0]       mem_waddr;
	logic [MW-1:0]       mem_wdata;
	logic                res_hit;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	lpht_mod #(
		.KEY_BITS (KEY_BITS)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (key),
		.divisor  (size_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign home       = IW'(mod_rem);
	assign idx_inc    = CW'(chk_idx_q) + CW'(1);
	assign nxt_idx    = (idx_inc >= CW'(size_q)) ? '0 : IW'(idx_inc);
	assign last_probe = (n_q == size_q - CFG_W'(1));
	assign rd_valid   = rd_word_s1[KEY_BITS];
	assign rd_match   = (rd_word_s1[KEY_BITS-1:0] == key_q);

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = nxt_idx;
		mem_we    = 1'b0;
		mem_waddr = chk_idx_q;
		mem_wdata = {1'b1, key_q};
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_HASH: begin
				mem_re    = mod_done;
				mem_raddr = home;
			end
			S_PROBE: begin
				// read the next slot ahead while this one is checked
				mem_re = 1'b1;
				mem_we = (act_q == ACT_INSERT) && !rd_valid;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_word_s1 <= slot_mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			size_q    <= clamp_size(SIZE_RESET, TABLE_DEPTH);
			key_q     <= '0;
			act_q     <= ACT_INSERT;
			chk_idx_q <= '0;
			n_q       <= '0;
			done_q    <= 1'b0;
			status_q  <= STAT_INSERTED;
			slot_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				// new size: drop every entry
				size_q  <= clamp_size(cfg_data, TABLE_DEPTH);
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end else begin
				case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + IW'(1);
						if (clr_q == IW'(TABLE_DEPTH - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (start) begin
							key_q   <= key;
							act_q   <= action;
							state_q <= S_HASH;
						end
					end
					S_HASH: begin
						if (mod_done) begin
							chk_idx_q <= home;
							n_q       <= '0;
							state_q   <= S_PROBE;
						end
					end
					S_PROBE: begin
						if (!rd_valid) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							if (act_q == ACT_INSERT) begin
								status_q <= STAT_INSERTED;
								slot_q   <= SLOT_W'(chk_idx_q);
							end else begin
								status_q <= STAT_MISSING;
								slot_q   <= '0;
							end
						end else if ((act_q == ACT_SEARCH) && rd_match) begin
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
							status_q <= STAT_FOUND;
							slot_q   <= SLOT_W'(chk_idx_q);
						end else if (last_probe) begin
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
							status_q <= (act_q == ACT_INSERT) ? STAT_FULL : STAT_MISSING;
							slot_q   <= '0;
						end else begin
							chk_idx_q <= nxt_idx;
							n_q       <= n_q + CFG_W'(1);
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign slot   = slot_q;

	assign res_hit = done_q && (status_q == STAT_INSERTED || status_q == STAT_FOUND);

`include "linear_probing_hash_table_top_assert.svh"

	`LPHT_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE || state_q == S_CLEAR, "result while busy")
	`LPHT_ASSERT_NEXT(a_take_busy, accept, busy, "accepted word did not start work")
	`LPHT_ASSERT_NOW(a_walk_bound, state_q == S_PROBE, n_q < size_q, "probe walk past table size")
	`LPHT_ASSERT_NOW(a_slot_range, res_hit, ({1'b0, slot_q} < size_q || IW > SLOT_W), "bad slot")

endmodule

[design/lpht_mod.sv]
`timescale 1ns / 1ps

module lpht_mod #(
	parameter int unsigned KEY_BITS = lpht_pkg::KEY_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [KEY_BITS-1:0]        dividend,
	input  logic [lpht_pkg::CFG_W-1:0] divisor,
	output logic                       done,
	output logic [lpht_pkg::CFG_W-1:0] rem
);
	import lpht_pkg::*;

	localparam int unsigned STEPS = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int unsigned PAD_W = STEPS * DIGIT_BITS;
	localparam int unsigned CNT_W = $clog2(STEPS + 1);

	logic [PAD_W-1:0] sh_q;
	logic [CFG_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [CFG_W-1:0] rem_nxt;

	// restoring remainder, one digit per cycle, most significant first
	always_comb begin
		logic [CFG_W:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < DIGIT_BITS; i++) begin
			r = {r[CFG_W-1:0], sh_q[PAD_W-1-i]};
			if (r >= {1'b0, divisor}) begin
				r = r - {1'b0, divisor};
			end
		end
		rem_nxt = r[CFG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sh_q   <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				sh_q  <= PAD_W'(dividend);
				rem_q <= '0;
				cnt_q <= CNT_W'(STEPS);
				run_q <= 1'b1;
			end else if (run_q) begin
				sh_q  <= sh_q << DIGIT_BITS;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
